[hdl/mat_pkg.sv]
package mat_pkg;

	localparam int DIST_BITS     = 41;
	localparam int CIRC_BITS     = 24;
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CIRC_BITS-1:0] CIRC_RESET = 24'd2202831;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_ZERO   = 1'b1
	} op_t;

	typedef enum logic {
		REG_CIRC    = 1'b0,
		REG_REVERSE = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic magnet_lost;
		logic read_failed;
	} sensor_flags_t;

endpackage

[hdl/multiturn_angle_tracker.sv]
// Multi-turn angle tracker. Each input word is a sample or a zero command with
// an absolute sensor angle; every word yields one result word with the turn
// count, the angle relative to the origin, the fault flag and the signed
// travelled distance (turns plus fraction, times the gear circumference, Q.16).
// Each word passes registers s1, s2, s3 and the output; one word is accepted
// per cycle as long as results are taken. A result stall freezes the pipeline,
// and a one-word skid register at the input raises item_stall in the next cycle.
// Configuration registers (circumference at 0x0, reverse sense at 0x4) must only
// be written while no words are in flight.
module multiturn_angle_tracker import mat_pkg::*; #(
	parameter int TURN_BITS  = 16,
	parameter int ANGLE_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [CFG_ADDR_BITS-1:0]     paddr,
	input  logic [CFG_DATA_BITS-1:0]     pwdata,
	output logic [CFG_DATA_BITS-1:0]     prdata,
	output logic                         pready,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         operation,
	input  logic [ANGLE_BITS-1:0]        raw_angle,
	input  logic                         magnet_lost,
	input  logic                         read_failed,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [DIST_BITS-1:0]  distance_q16,
	output logic signed [TURN_BITS-1:0]  turn_count,
	output logic [ANGLE_BITS-1:0]        angle_in_turn,
	output logic                         fault
);

	logic [CIRC_BITS-1:0] circ_q;
	logic                 reverse_q;
	reg_index_t           reg_sel;

	logic                 en;
	logic                 in_accept;

	logic                 skid_v_q;
	op_t                  skid_op_q;
	logic [ANGLE_BITS-1:0] skid_raw_q;
	sensor_flags_t        skid_flags_q;

	logic                 v_s1;
	op_t                  op_s1;
	logic [ANGLE_BITS-1:0] raw_s1;
	sensor_flags_t        flags_s1;

	logic signed [TURN_BITS-1:0] turns_nxt;
	logic [ANGLE_BITS-1:0]       angle_nxt;
	logic                        fault_nxt;

	logic                        v_s2;
	logic signed [TURN_BITS-1:0] turns_s2;
	logic [ANGLE_BITS-1:0]       angle_s2;
	logic                        fault_s2;

	logic                        v_s3;
	logic signed [TURN_BITS-1:0] turns_s3;
	logic [ANGLE_BITS-1:0]       angle_s3;
	logic                        fault_s3;

	logic signed [DIST_BITS-1:0] distance_w;

	sensor_flags_t               in_flags;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q    <= CIRC_RESET;
			reverse_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_CIRC:    circ_q    <= pwdata[CIRC_BITS-1:0];
				REG_REVERSE: reverse_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CIRC:    prdata = {{(CFG_DATA_BITS-CIRC_BITS){1'b0}}, circ_q};
			REG_REVERSE: prdata = {{(CFG_DATA_BITS-1){1'b0}}, reverse_q};
			default:     prdata = '0;
		endcase
	end

	// Pipeline control: every stage advances unless the result word is stalled.
	assign en         = !(result_valid && result_stall);
	assign item_stall = skid_v_q;
	assign in_accept  = item_valid && !item_stall;

	assign in_flags.magnet_lost = magnet_lost;
	assign in_flags.read_failed = read_failed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q     <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (en) begin
				skid_v_q     <= 1'b0;
				v_s1         <= skid_v_q || in_accept;
				v_s2         <= v_s1;
				v_s3         <= v_s2;
				result_valid <= v_s3;
			end else if (in_accept) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!en && in_accept) begin
			skid_op_q    <= op_t'(operation);
			skid_raw_q   <= raw_angle;
			skid_flags_q <= in_flags;
		end
		if (en) begin
			if (skid_v_q) begin
				op_s1    <= skid_op_q;
				raw_s1   <= skid_raw_q;
				flags_s1 <= skid_flags_q;
			end else begin
				op_s1    <= op_t'(operation);
				raw_s1   <= raw_angle;
				flags_s1 <= in_flags;
			end
			turns_s2      <= turns_nxt;
			angle_s2      <= angle_nxt;
			fault_s2      <= fault_nxt;
			turns_s3      <= turns_s2;
			angle_s3      <= angle_s2;
			fault_s3      <= fault_s2;
			distance_q16  <= distance_w;
			turn_count    <= turns_s3;
			angle_in_turn <= angle_s3;
			fault         <= fault_s3;
		end
	end

	mat_update #(
		.TURN_BITS  (TURN_BITS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (en && v_s1),
		.op        (op_s1),
		.raw       (raw_s1),
		.flags     (flags_s1),
		.turns_nxt (turns_nxt),
		.angle_nxt (angle_nxt),
		.fault_nxt (fault_nxt)
	);

	mat_dist #(
		.TURN_BITS  (TURN_BITS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_dist (
		.clk      (clk),
		.en       (en),
		.turns    (turns_s2),
		.angle    (angle_s2),
		.circ     (circ_q),
		.reverse  (reverse_q),
		.distance (distance_w)
	);

endmodule

[hdl/mat_update.sv]
module mat_update import mat_pkg::*; #(
	parameter int TURN_BITS  = 16,
	parameter int ANGLE_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  op_t                          op,
	input  logic [ANGLE_BITS-1:0]        raw,
	input  sensor_flags_t                flags,
	output logic signed [TURN_BITS-1:0]  turns_nxt,
	output logic [ANGLE_BITS-1:0]        angle_nxt,
	output logic                         fault_nxt
);

	localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};
	localparam logic [ANGLE_BITS-1:0] THREE_Q = {2'b11, {(ANGLE_BITS-2){1'b0}}};
	localparam logic [TURN_BITS-1:0]  TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
	localparam logic [TURN_BITS-1:0]  TURN_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

	logic [ANGLE_BITS-1:0]       origin_q;
	logic signed [TURN_BITS-1:0] turns_q;
	logic [ANGLE_BITS-1:0]       angle_q;
	logic                        fault_q;

	logic [ANGLE_BITS-1:0] origin_nxt;
	logic [ANGLE_BITS-1:0] rel;

	always_comb begin
		origin_nxt = origin_q;
		turns_nxt  = turns_q;
		angle_nxt  = angle_q;
		fault_nxt  = fault_q;
		// Angle relative to the origin wraps naturally at the angle width.
		rel        = raw - origin_q;
		case (op)
			OP_ZERO: begin
				turns_nxt = '0;
				angle_nxt = '0;
				fault_nxt = flags.read_failed | flags.magnet_lost;
				if (!(flags.read_failed || flags.magnet_lost)) begin
					origin_nxt = raw;
				end
			end
			OP_SAMPLE: begin
				if (!fault_q && !flags.read_failed) begin
					if (flags.magnet_lost) begin
						fault_nxt = 1'b1;
					end else begin
						if (rel < QUARTER && angle_q > THREE_Q) begin
							if (turns_q != $signed(TURN_MAX)) begin
								turns_nxt = turns_q + TURN_BITS'(1);
							end
						end else if (rel > THREE_Q && angle_q < QUARTER) begin
							if (turns_q != $signed(TURN_MIN)) begin
								turns_nxt = turns_q - TURN_BITS'(1);
							end
						end
						angle_nxt = rel;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			turns_q  <= '0;
			angle_q  <= '0;
			fault_q  <= 1'b0;
		end else if (step) begin
			origin_q <= origin_nxt;
			turns_q  <= turns_nxt;
			angle_q  <= angle_nxt;
			fault_q  <= fault_nxt;
		end
	end

endmodule

[hdl/mat_dist.sv]
module mat_dist import mat_pkg::*; #(
	parameter int TURN_BITS  = 16,
	parameter int ANGLE_BITS = 12
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [TURN_BITS-1:0]  turns,
	input  logic [ANGLE_BITS-1:0]        angle,
	input  logic [CIRC_BITS-1:0]         circ,
	input  logic                         reverse,
	output logic signed [DIST_BITS-1:0]  distance
);

	localparam int HW = TURN_BITS + CIRC_BITS;
	localparam int LW = ANGLE_BITS + CIRC_BITS + 1;
	localparam int SW = (HW + 1 > DIST_BITS + 1) ? HW + 1 : DIST_BITS + 1;
	localparam logic [LW-1:0] HALF    = LW'(1) << (ANGLE_BITS - 1);
	localparam logic [SW-1:0] NEG_MAX = SW'(1) << (DIST_BITS - 1);
	localparam logic [SW-1:0] POS_MAX = (SW'(1) << (DIST_BITS - 1)) - SW'(1);

	logic                     neg;
	logic [TURN_BITS-1:0]     hi;
	logic [ANGLE_BITS-1:0]    lo;

	logic [HW-1:0]            phi_s3;
	logic [LW-2:0]            plo_s3;
	logic                     neg_s3;

	logic [LW-1:0]            lo_round;
	logic [SW-1:0]            total;
	logic [SW-1:0]            mag;
	logic [DIST_BITS-1:0]     dist_w;

	// Split the magnitude of turns * 2^ANGLE_BITS + angle into whole turns and
	// the fraction of a turn without forming the wide sum.
	always_comb begin
		neg = turns[TURN_BITS-1];
		hi  = turns;
		lo  = angle;
		if (neg) begin
			if (angle == '0) begin
				hi = -turns;
				lo = '0;
			end else begin
				hi = ~turns;
				lo = -angle;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s3 <= HW'(hi) * HW'(circ);
			plo_s3 <= (LW-1)'(lo) * (LW-1)'(circ);
			neg_s3 <= neg ^ reverse;
		end
	end

	always_comb begin
		lo_round = LW'(plo_s3) + HALF;
		total    = SW'(phi_s3) + SW'(lo_round[LW-1:ANGLE_BITS]);
		mag      = total;
		dist_w   = '0;
		if (total != '0) begin
			if (neg_s3) begin
				if (total > NEG_MAX) begin
					mag = NEG_MAX;
				end
				dist_w = -mag[DIST_BITS-1:0];
			end else begin
				if (total > POS_MAX) begin
					mag = POS_MAX;
				end
				dist_w = mag[DIST_BITS-1:0];
			end
		end
	end

	assign distance = $signed(dist_w);

endmodule

[hdl/mat_chk.sv]
module mat_chk import mat_pkg::*; #(
	parameter int TURN_BITS  = 16,
	parameter int ANGLE_BITS = 12
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_stall,
	input logic                         result_valid,
	input logic                         result_stall,
	input logic signed [DIST_BITS-1:0]  distance_q16,
	input logic signed [TURN_BITS-1:0]  turn_count,
	input logic [ANGLE_BITS-1:0]        angle_in_turn,
	input logic                         fault
);

	// A stalled result word holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(distance_q16)
			&& $stable(turn_count) && $stable(angle_in_turn) && $stable(fault))
		else $error("result word changed while stalled");

	// With no result pending the pipeline moves, so the input skid stays empty.
	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |=> !item_stall)
		else $error("input stalled although no result was pending");

	// Input back-pressure only starts after a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(result_valid && result_stall))
		else $error("input stall raised without a result stall");

endmodule

bind multiturn_angle_tracker mat_chk #(
	.TURN_BITS  (TURN_BITS),
	.ANGLE_BITS (ANGLE_BITS)
) u_mat_chk (.*);

[verif/angle_checker.sv]
`timescale 1ns / 100ps

module angle_checker import mat_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [CFG_ADDR_BITS-1:0]    paddr,
	input  logic [CFG_DATA_BITS-1:0]    pwdata,
	input  logic                        pready,
	input  logic                        item_valid,
	input  logic                        item_stall,
	input  logic                        operation,
	input  logic [11:0]                 raw_angle,
	input  logic                        magnet_lost,
	input  logic                        read_failed,
	input  logic                        result_valid,
	input  logic                        result_stall,
	input  logic signed [DIST_BITS-1:0] distance_q16,
	input  logic signed [15:0]          turn_count,
	input  logic [11:0]                 angle_in_turn,
	input  logic                        fault,
	output int                          mismatches,
	output int                          outstanding,
	output int                          results_seen
);

	localparam logic [11:0] QUARTER_TURN = 12'd1024;
	localparam logic [11:0] LAST_QUARTER = 12'd3072;
	localparam logic signed [15:0] TURNS_TOP    = 16'sh7FFF;
	localparam logic signed [15:0] TURNS_BOTTOM = 16'sh8000;
	localparam longint unsigned DIST_POS_LIMIT = (64'd1 << (DIST_BITS - 1)) - 64'd1;
	localparam longint unsigned DIST_NEG_LIMIT = 64'd1 << (DIST_BITS - 1);
	localparam int REPORT_LIMIT = 30;

	typedef struct packed {
		logic signed [DIST_BITS-1:0] travel;
		logic signed [15:0]          turns;
		logic [11:0]                 angle;
		logic                        halted;
	} tracker_word_t;

	tracker_word_t expected_words[$];

	logic [CIRC_BITS-1:0] circumference;
	logic                 reversed;
	logic [11:0]          origin;
	logic [11:0]          last_rel;
	logic signed [15:0]   turns;
	logic                 halted;
	int                   fails;
	int                   results;

	// Whole turns plus fraction times the circumference; the magnitude is rounded
	// half away from zero before the sign goes on.
	function automatic logic signed [DIST_BITS-1:0] travelled(
		input logic signed [15:0] t, input logic [11:0] a,
		input logic [CIRC_BITS-1:0] circ, input logic rev);
		longint          pos;
		logic            neg;
		longint unsigned mag;
		longint unsigned total;
		pos = longint'(t) * 4096 + longint'(a);
		neg = pos < 0;
		mag = neg ? longint'(-pos) : pos;
		total = (mag >> 12) * circ + (((mag & 64'd4095) * circ + 64'd2048) >> 12);
		if (rev)
			neg = !neg;
		if (total == 0)
			return '0;
		if (neg) begin
			if (total > DIST_NEG_LIMIT)
				total = DIST_NEG_LIMIT;
			return DIST_BITS'(64'd0 - total);
		end
		if (total > DIST_POS_LIMIT)
			total = DIST_POS_LIMIT;
		return DIST_BITS'(total);
	endfunction

	task automatic track_word(input op_t op, input logic [11:0] raw, input logic no_magnet,
		input logic failed);
		logic [11:0]   rel;
		tracker_word_t word;
		if (op == OP_ZERO) begin
			turns = '0;
			last_rel = '0;
			halted = 1'b0;
			if (failed || no_magnet)
				halted = 1'b1;
			else
				origin = raw;
		end else if (!halted && !failed) begin
			if (no_magnet) begin
				halted = 1'b1;
			end else begin
				rel = raw - origin;
				if (rel < QUARTER_TURN && last_rel > LAST_QUARTER) begin
					if (turns != TURNS_TOP)
						turns = turns + 16'sd1;
				end else if (rel > LAST_QUARTER && last_rel < QUARTER_TURN) begin
					if (turns != TURNS_BOTTOM)
						turns = turns - 16'sd1;
				end
				last_rel = rel;
			end
		end
		word.travel = travelled(turns, last_rel, circumference, reversed);
		word.turns = turns;
		word.angle = last_rel;
		word.halted = halted;
		expected_words.push_back(word);
	endtask

	task automatic compare_result();
		tracker_word_t want;
		results++;
		if (expected_words.size() == 0) begin
			fails++;
			if (fails <= REPORT_LIMIT)
				$error("result word arrived with no expected word pending");
			return;
		end
		want = expected_words.pop_front();
		if (distance_q16 !== want.travel) begin
			fails++;
			if (fails <= REPORT_LIMIT)
				$error("distance_q16 expected %0d, got %0d", want.travel, distance_q16);
		end
		if (turn_count !== want.turns) begin
			fails++;
			if (fails <= REPORT_LIMIT)
				$error("turn_count expected %0d, got %0d", want.turns, turn_count);
		end
		if (angle_in_turn !== want.angle) begin
			fails++;
			if (fails <= REPORT_LIMIT)
				$error("angle_in_turn expected %0d, got %0d", want.angle, angle_in_turn);
		end
		if (fault !== want.halted) begin
			fails++;
			if (fails <= REPORT_LIMIT)
				$error("fault expected %0b, got %0b", want.halted, fault);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circumference = CIRC_RESET;
			reversed = 1'b0;
			origin = '0;
			last_rel = '0;
			turns = '0;
			halted = 1'b0;
			fails = 0;
			results = 0;
			expected_words.delete();
			mismatches <= 0;
			outstanding <= 0;
			results_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_index_t'(paddr[2]))
					REG_CIRC:    circumference = pwdata[CIRC_BITS-1:0];
					REG_REVERSE: reversed = pwdata[0];
					default: ;
				endcase
			end
			// A result taken at this edge always belongs to an earlier word.
			if (result_valid && !result_stall)
				compare_result();
			if (item_valid && !item_stall)
				track_word(op_t'(operation), raw_angle, magnet_lost, read_failed);
			mismatches <= fails;
			outstanding <= expected_words.size();
			results_seen <= results;
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import mat_pkg::*;

	localparam int HOLD_CYCLES = 80;
	localparam int SPIN_TURNS  = 10;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [CFG_ADDR_BITS-1:0]    paddr;
	logic [CFG_DATA_BITS-1:0]    pwdata;
	logic [CFG_DATA_BITS-1:0]    prdata;
	logic                        pready;
	logic                        item_valid;
	logic                        item_stall;
	logic                        operation;
	logic [11:0]                 raw_angle;
	logic                        magnet_lost;
	logic                        read_failed;
	logic                        result_valid;
	logic                        result_stall;
	logic signed [DIST_BITS-1:0] distance_q16;
	logic signed [15:0]          turn_count;
	logic [11:0]                 angle_in_turn;
	logic                        fault;

	int          mismatches;
	int          outstanding;
	int          results_seen;
	int          words_sent;
	int          settings_used;
	bit          steady;
	bit          hold_req;
	bit          hold_done;
	logic [11:0] shaft;

	multiturn_angle_tracker i_dut (.*);

	angle_checker i_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off so the pipeline and the
	// input skid fill up while the sender keeps offering words.
	initial begin
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= !steady && ($urandom_range(99) < 18);
			end
		end
	end

	task automatic send_word(input op_t op, input logic [11:0] ang, input logic no_magnet,
		input logic failed);
		if (!steady && $urandom_range(99) < 18) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		raw_angle <= ang;
		magnet_lost <= no_magnet;
		read_failed <= failed;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_BITS'(4 * int'(idx));
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_gearing(input logic [CIRC_BITS-1:0] circ, input logic rev);
		drain();
		write_reg(REG_CIRC, CFG_DATA_BITS'(circ));
		write_reg(REG_REVERSE, CFG_DATA_BITS'(rev));
		settings_used++;
	endtask

	// Mostly a shaft turning in modest steps so the quadrant crossings happen, with
	// zero commands, sensor faults and wild jumps mixed in.
	task automatic random_word();
		int          pick;
		op_t         op;
		logic        no_magnet;
		logic        failed;
		logic [11:0] ang;
		pick = $urandom_range(999);
		op = OP_SAMPLE;
		no_magnet = 1'b0;
		failed = 1'b0;
		if (pick < 50) begin
			op = OP_ZERO;
			shaft = 12'($urandom);
			if ($urandom_range(3) == 0) begin
				no_magnet = 1'($urandom_range(1));
				failed = !no_magnet || $urandom_range(1);
			end
		end else if (pick < 65) begin
			no_magnet = 1'b1;
			failed = 1'($urandom_range(1));
		end else if (pick < 115) begin
			failed = 1'b1;
			no_magnet = 1'($urandom_range(1));
		end else if (pick < 160) begin
			shaft = 12'($urandom);
		end else begin
			shaft = shaft + 12'($urandom_range(1200)) - 12'd600;
		end
		ang = failed ? 12'($urandom) : shaft;
		send_word(op, ang, no_magnet, failed);
	endtask

	// Three samples per turn, either way round.
	task automatic spin_turns(input int count, input bit forward);
		logic [11:0] base;
		int          i;
		base = 12'($urandom);
		send_word(OP_ZERO, base, 1'b0, 1'b0);
		for (i = 0; i < count; i++) begin
			if (forward) begin
				send_word(OP_SAMPLE, base + 12'(1100 + $urandom_range(1900)), 1'b0, 1'b0);
				send_word(OP_SAMPLE, base + 12'(3100 + $urandom_range(995)), 1'b0, 1'b0);
				send_word(OP_SAMPLE, base + 12'($urandom_range(1000)), 1'b0, 1'b0);
			end else begin
				send_word(OP_SAMPLE, base + 12'(3100 + $urandom_range(995)), 1'b0, 1'b0);
				send_word(OP_SAMPLE, base + 12'(1100 + $urandom_range(1900)), 1'b0, 1'b0);
				send_word(OP_SAMPLE, base + 12'($urandom_range(1000)), 1'b0, 1'b0);
			end
		end
	endtask

	initial begin
		int i;
		clk = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_valid <= 1'b0;
		operation <= OP_SAMPLE;
		raw_angle <= '0;
		magnet_lost <= 1'b0;
		read_failed <= 1'b0;
		words_sent = 0;
		settings_used = 1;
		steady = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		shaft = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Quadrant boundaries, wrap of the relative angle, and every fault path.
		send_word(OP_SAMPLE, 12'd0, 1'b0, 1'b0);
		send_word(OP_ZERO, 12'd100, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd100, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd3600, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd3172, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd1123, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd3173, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd1124, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd99, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd100, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd4095, 1'b0, 1'b1);
		send_word(OP_SAMPLE, 12'd0, 1'b1, 1'b1);
		send_word(OP_SAMPLE, 12'd2000, 1'b1, 1'b0);
		send_word(OP_SAMPLE, 12'd300, 1'b0, 1'b0);
		send_word(OP_ZERO, 12'd2222, 1'b1, 1'b0);
		send_word(OP_SAMPLE, 12'd150, 1'b0, 1'b0);
		send_word(OP_ZERO, 12'd3333, 1'b0, 1'b1);
		send_word(OP_ZERO, 12'd4095, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd0, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd4094, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd4095, 1'b0, 1'b0);
		send_word(OP_ZERO, 12'd0, 1'b0, 1'b0);
		send_word(OP_SAMPLE, 12'd4095, 1'b0, 1'b0);

		set_gearing(24'hFFFFFF, 1'b1);
		for (i = 0; i < 120; i++)
			random_word();
		set_gearing(24'd0, 1'b0);
		for (i = 0; i < 40; i++)
			random_word();
		set_gearing(24'd1, 1'b1);
		for (i = 0; i < 40; i++)
			random_word();

		// Spin the shaft a few whole turns each way at the largest circumference.
		set_gearing(24'hFFFFFF, 1'b0);
		steady = 1'b1;
		spin_turns(SPIN_TURNS, 1'b1);
		steady = 1'b0;
		set_gearing(24'hFFFFFF, 1'b1);
		steady = 1'b1;
		spin_turns(SPIN_TURNS, 1'b0);
		steady = 1'b0;

		set_gearing(24'($urandom), 1'($urandom));
		for (i = 0; i < 330; i++) begin
			steady = (i >= 100 && i < 200);
			if (i == 250)
				hold_req = 1'b1;
			random_word();
		end
		steady = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d words and checked %0d results under %0d gear settings.",
			words_sent, results_seen, settings_used);
		$display("Shaft spun %0d turns each way; one long result hold-off.", SPIN_TURNS);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
